// ----- sv/lcl_pkg.sv -----
// ----------------------------------------------------------------------------
// lcl_pkg
// Shared constants and codes for the line and column locator.
// ----------------------------------------------------------------------------
`default_nettype none

package lcl_pkg;

    localparam int MAX_LINES     = 2048;
    localparam int POSITION_BITS = 24;
    localparam int IDX_BITS      = $clog2(MAX_LINES);
    localparam int COUNT_BITS    = $clog2(MAX_LINES + 1);
    localparam int LINE_BITS     = 12;
    localparam int COL_BITS      = 25;
    localparam int QUERY_BITS    = 24;
    localparam int CMD_BITS      = 2;
    localparam int CHAR_BITS     = 8;

    localparam int IN_BITS       = CMD_BITS + CHAR_BITS + QUERY_BITS;
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS      = LINE_BITS + COL_BITS + 1;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CHAR_BITS-1:0] CHAR_CR = 8'd13;
    localparam logic [CHAR_BITS-1:0] CHAR_LF = 8'd10;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CHAR  = 2'd0,
        CMD_END   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

endpackage

`default_nettype wire

// ----- sv/line_column_locator.sv -----
// ----------------------------------------------------------------------------
// line_column_locator
// Follows a character stream, records line starts in a table memory and
// answers position queries with a line and column by binary search.
// ----------------------------------------------------------------------------
//   channel   direction  fields (lowest bit up)
//   s_*       in         command[1:0], character[9:2], query_position[33:10]
//   m_*       out        line_number[11:0], column_number[36:12],
//                        table_full[37]
//
// Character and end-of-input transactions are accepted back to back while idle.
// A query runs at most ceil(log2(count+1)) search steps (12 with 2048
// lines): each step is one read of the single-port line table followed
// by one compare of its registered data; a final bounds check ends it.
// A query past the stream end skips the search.
// Reset clears position, count and flags; the table needs no clearing.
// A result waits in the output register; only a query that finishes while
// it is still held stalls until the output side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module line_column_locator
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // command[1:0], character[9:2], query_position[33:10], zero fill
    input  wire logic [lcl_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // line_number[11:0], column_number[36:12], table_full[37], zero fill
    output logic [lcl_pkg::OUT_TDATA_BITS-1:0]       m_tdata
);

    localparam int PB = lcl_pkg::POSITION_BITS;
    localparam int CB = lcl_pkg::COUNT_BITS;
    localparam int IB = lcl_pkg::IDX_BITS;
    localparam int LB = lcl_pkg::LINE_BITS;
    localparam int OB = lcl_pkg::COL_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [PB-1:0]       pos_reg;
    logic [CB-1:0]       count_reg;
    logic                full_reg;
    logic [PB-1:0]       q_reg;
    logic [CB-1:0]       lo_reg;
    logic [CB-1:0]       hi_reg;
    logic [PB-1:0]       base_reg;
    logic [LB-1:0]       line_reg;
    logic [OB-1:0]       col_reg;
    logic                m_tvalid_reg;
    logic [lcl_pkg::OUT_TDATA_BITS-1:0] m_tdata_reg;

    logic [PB-1:0]       mem [lcl_pkg::MAX_LINES];
    logic [PB-1:0]       rd_data_reg;

    lcl_pkg::cmd_t               in_cmd;
    logic [lcl_pkg::CHAR_BITS-1:0]  in_char;
    logic [lcl_pkg::QUERY_BITS-1:0] in_query;
    logic [PB-1:0]       q_in;
    logic                accept;
    logic                advance;
    logic [PB-1:0]       pos_next;
    logic                wr_en;
    logic                rd_en;
    logic [CB-1:0]       mid;
    logic                out_free;

    assign in_cmd   = lcl_pkg::cmd_t'(s_tdata[1:0]);
    assign in_char  = s_tdata[9:2];
    assign in_query = s_tdata[33:10];
    assign q_in     = in_query[PB-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign advance  = accept && ((in_cmd == lcl_pkg::CMD_END) ||
                      ((in_cmd == lcl_pkg::CMD_CHAR) && (in_char != lcl_pkg::CHAR_CR)));
    assign pos_next = (pos_reg == lcl_pkg::POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign wr_en    = accept && (in_cmd == lcl_pkg::CMD_CHAR) &&
                      (in_char == lcl_pkg::CHAR_LF) &&
                      (count_reg < CB'(lcl_pkg::MAX_LINES));

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_en    = (state_reg == S_READ) && (lo_reg < hi_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // line table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IB-1:0]] <= pos_next;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[mid[IB-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            count_reg    <= '0;
            full_reg     <= 1'b0;
            q_reg        <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            base_reg     <= '0;
            line_reg     <= '0;
            col_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // drop the held result once taken; a finishing query reloads it below
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (advance)
                    begin
                        pos_reg <= pos_next;
                    end
                    if (wr_en)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    else if (accept && (in_cmd == lcl_pkg::CMD_CHAR) &&
                             (in_char == lcl_pkg::CHAR_LF))
                    begin
                        full_reg <= 1'b1;
                    end
                    if (accept && (in_cmd == lcl_pkg::CMD_QUERY))
                    begin
                        q_reg    <= q_in;
                        lo_reg   <= '0;
                        hi_reg   <= count_reg;
                        base_reg <= '0;
                        if (q_in > pos_reg)
                        begin
                            // beyond the stream: answer line and column zero
                            line_reg  <= '0;
                            col_reg   <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end

                S_READ:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        line_reg  <= LB'(lo_reg) + 1'b1;
                        col_reg   <= {1'b0, q_reg} - {1'b0, base_reg} + 1'b1;
                        state_reg <= S_DONE;
                    end
                end

                S_CMP:
                begin
                    // keep the last entry not above the query as the line base
                    if (rd_data_reg <= q_reg)
                    begin
                        lo_reg   <= mid + 1'b1;
                        base_reg <= rd_data_reg;
                    end
                    else
                    begin
                        hi_reg <= mid;
                    end
                    state_reg <= S_READ;
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= lcl_pkg::OUT_TDATA_BITS'({full_reg, col_reg, line_reg});
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb_line_column_locator.sv -----
// ----------------------------------------------------------------------------
// tb_line_column_locator
// Drives character, end-of-input, query and unused-command transactions into
// the locator, keeps its own table of line starts to predict each query's
// line, column and full flag, and checks every result in arrival order.
// Covers an empty stream, empty lines and queries past the stream end.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_line_column_locator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 550;

    typedef struct packed {
        logic                          full;
        logic [lcl_pkg::COL_BITS-1:0]  col;
        logic [lcl_pkg::LINE_BITS-1:0] line;
    } location_t;

    class locator_scoreboard;
        logic [lcl_pkg::POSITION_BITS-1:0] position;
        int unsigned                       line_count;
        logic [lcl_pkg::POSITION_BITS-1:0] line_starts [lcl_pkg::MAX_LINES];
        bit                                full_seen;
        location_t                         pending_locations [$];
        int                                failures;

        function void clear();
            position   = '0;
            line_count = 0;
            full_seen  = 1'b0;
            failures   = 0;
            pending_locations.delete();
        endfunction

        function void advance();
            if (position != lcl_pkg::POS_MAX)
                position = position + 1'b1;
        endfunction

        // Number of recorded line starts that are not above q.
        function int unsigned starts_not_above(logic [lcl_pkg::POSITION_BITS-1:0] q);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = line_count;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (line_starts[mid] <= q)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function void take_item(lcl_pkg::cmd_t cmd, logic [lcl_pkg::CHAR_BITS-1:0] ch,
                                logic [lcl_pkg::QUERY_BITS-1:0] q);
            location_t                         loc;
            int unsigned                       k;
            logic [lcl_pkg::POSITION_BITS-1:0] base;
            case (cmd)
                lcl_pkg::CMD_CHAR:
                begin
                    if (ch != lcl_pkg::CHAR_CR)
                    begin
                        advance();
                        if (ch == lcl_pkg::CHAR_LF)
                        begin
                            if (line_count < lcl_pkg::MAX_LINES)
                            begin
                                line_starts[line_count] = position;
                                line_count++;
                            end
                            else
                                full_seen = 1'b1;
                        end
                    end
                end
                lcl_pkg::CMD_END:
                    advance();
                lcl_pkg::CMD_QUERY:
                begin
                    loc.full = full_seen;
                    loc.line = '0;
                    loc.col  = '0;
                    if (q <= position)
                    begin
                        k        = starts_not_above(q);
                        base     = (k != 0) ? line_starts[k-1] : '0;
                        loc.line = lcl_pkg::LINE_BITS'(k + 1);
                        loc.col  = lcl_pkg::COL_BITS'(q - base) + 1'b1;
                    end
                    pending_locations.push_back(loc);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [lcl_pkg::OUT_TDATA_BITS-1:0] data);
            location_t got;
            location_t want;
            got = location_t'(data[lcl_pkg::OUT_BITS-1:0]);
            if (pending_locations.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: line %0d column %0d full %0d",
                             got.line, got.col, got.full);
                return;
            end
            want = pending_locations.pop_front();
            if (got.line != want.line || got.col != want.col || got.full != want.full)
            begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch: line exp %0d got %0d, column exp %0d got %0d,",
                              " full exp %0d got %0d"},
                             want.line, got.line, want.col, got.col, want.full, got.full);
            end
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [lcl_pkg::IN_TDATA_BITS-1:0]  s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [lcl_pkg::OUT_TDATA_BITS-1:0] m_tdata;

    locator_scoreboard board;
    int                burst_left;
    int                idle_cycles;
    int                ready_mode;
    int                ready_left;

    line_column_locator u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Receiver: switch between always ready, coin flip and mostly stalled.
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(8, 80);
        end
        ready_left--;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Present one transaction in bursts with random gaps; return at the
    // falling edge after it was accepted.
    task automatic send_item(lcl_pkg::cmd_t cmd, logic [lcl_pkg::CHAR_BITS-1:0] ch,
                             logic [lcl_pkg::QUERY_BITS-1:0] q);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 60);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(lcl_pkg::IN_TDATA_BITS-lcl_pkg::IN_BITS){1'b0}}, q, ch, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        board.take_item(cmd, ch, q);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_query(logic [lcl_pkg::QUERY_BITS-1:0] q);
        send_item(lcl_pkg::CMD_QUERY, lcl_pkg::CHAR_BITS'($urandom), q);
    endtask

    // Hold the sender until every expected result has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (board.pending_locations.size() != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    task automatic random_query();
        logic [lcl_pkg::QUERY_BITS-1:0] q;
        logic [lcl_pkg::QUERY_BITS-1:0] start;
        start = (board.line_count != 0) ?
                board.line_starts[$urandom_range(0, board.line_count - 1)] : '0;
        case ($urandom_range(0, 5))
            0:       q = start;
            1:       q = start - 1'b1;
            2:       q = start + 1'b1;
            3:       q = lcl_pkg::QUERY_BITS'($urandom_range(0, board.position));
            4:       q = board.position + lcl_pkg::QUERY_BITS'($urandom_range(0, 1));
            default: q = lcl_pkg::QUERY_BITS'($urandom);
        endcase
        send_query(q);
    endtask

    task automatic random_item();
        int                             pick;
        logic [lcl_pkg::CHAR_BITS-1:0]  ch;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: ch = lcl_pkg::CHAR_LF;
                3:       ch = lcl_pkg::CHAR_CR;
                default: ch = lcl_pkg::CHAR_BITS'($urandom_range(0, 255));
            endcase
            send_item(lcl_pkg::CMD_CHAR, ch, lcl_pkg::QUERY_BITS'($urandom));
        end
        else if (pick < 62)
            send_item(lcl_pkg::CMD_END, lcl_pkg::CHAR_BITS'($urandom),
                      lcl_pkg::QUERY_BITS'($urandom));
        else if (pick < 65)
            send_item(lcl_pkg::CMD_NONE, lcl_pkg::CHAR_BITS'($urandom),
                      lcl_pkg::QUERY_BITS'($urandom));
        else
            random_query();
    endtask

    initial
    begin
        board      = new;
        board.clear();
        burst_left = 0;
        ready_left = 0;
        idle_cycles = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty stream, extreme bytes, carriage return, empty lines.
        send_query('0);
        send_query({lcl_pkg::QUERY_BITS{1'b1}});
        send_item(lcl_pkg::CMD_CHAR, 8'h00, '0);
        send_item(lcl_pkg::CMD_CHAR, 8'hFF, {lcl_pkg::QUERY_BITS{1'b1}});
        send_item(lcl_pkg::CMD_CHAR, lcl_pkg::CHAR_CR, '0);
        send_item(lcl_pkg::CMD_CHAR, lcl_pkg::CHAR_LF, '0);
        send_query('0);
        send_query(24'd2);
        send_query(24'd3);
        send_item(lcl_pkg::CMD_END, lcl_pkg::CHAR_LF, 24'd7);
        send_query(24'd4);
        send_query(24'd5);
        send_item(lcl_pkg::CMD_NONE, lcl_pkg::CHAR_LF, '0);
        send_item(lcl_pkg::CMD_NONE, 8'hFF, {lcl_pkg::QUERY_BITS{1'b1}});
        send_query(24'd4);
        send_item(lcl_pkg::CMD_CHAR, lcl_pkg::CHAR_LF, '0);
        send_item(lcl_pkg::CMD_CHAR, lcl_pkg::CHAR_LF, '0);
        send_item(lcl_pkg::CMD_CHAR, lcl_pkg::CHAR_CR, '0);
        send_query(24'd5);
        send_query(24'd6);
        send_query(24'd7);
        send_query(24'd8);
        send_item(lcl_pkg::CMD_END, 8'h00, '0);
        send_query(24'd7);
        send_query(24'h800000);

        repeat (RANDOM_ITEMS / 2) random_item();
        drain();
        repeat (RANDOM_ITEMS - RANDOM_ITEMS / 2) random_item();

        s_tvalid <= 1'b0;
        while (board.pending_locations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.failures == 0 && board.pending_locations.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ----- line_column_locator.f -----
sv/lcl_pkg.sv
sv/line_column_locator.sv
bench/tb_line_column_locator.sv
